/* hw/rtl/dte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_pkg: shared types and constants for the date-time text converter
// Character codes, text layout, the parsed-record type passed from the
// front parser to the back converter, and calendar lookup functions.
// ----------------------------------------------------------------------------
package dte_pkg;

  // text layout "YYYY-MM-DD HH:MM:SS"
  localparam int unsigned TEXT_LEN    = 19;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ACC_W       = 7;
  localparam int unsigned SEC_W       = 39;

  localparam logic [POS_W-1:0] POS_DASH1  = 5'd4;
  localparam logic [POS_W-1:0] POS_DASH2  = 5'd7;
  localparam logic [POS_W-1:0] POS_SPACE  = 5'd10;
  localparam logic [POS_W-1:0] POS_COLON1 = 5'd13;
  localparam logic [POS_W-1:0] POS_COLON2 = 5'd16;
  localparam logic [POS_W-1:0] POS_LAST   = 5'd18;
  localparam logic [POS_W-1:0] POS_END    = 5'd19;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // one parsed text; the year is kept as century and year-of-century digit pairs
  typedef struct packed {
    logic             fmt_ok;
    logic [ACC_W-1:0] yc;
    logic [ACC_W-1:0] yl;
    logic [ACC_W-1:0] mon;
    logic [ACC_W-1:0] day;
    logic [ACC_W-1:0] hr;
    logic [ACC_W-1:0] mi;
    logic [ACC_W-1:0] sc;
  } rec_t;

  // days in month, zero for a month out of range
  function automatic logic [4:0] month_len(input logic [ACC_W-1:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                     len = 5'd30;
      7'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // day-of-year of the first of a month, in a year that starts in March
  function automatic logic [8:0] doy_base(input logic [ACC_W-1:0] m);
    logic [8:0] base;
    unique case (m)
      7'd3:    base = 9'd0;
      7'd4:    base = 9'd31;
      7'd5:    base = 9'd61;
      7'd6:    base = 9'd92;
      7'd7:    base = 9'd122;
      7'd8:    base = 9'd153;
      7'd9:    base = 9'd184;
      7'd10:   base = 9'd214;
      7'd11:   base = 9'd245;
      7'd12:   base = 9'd275;
      7'd1:    base = 9'd306;
      7'd2:    base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

/* hw/rtl/datetime_text_to_epoch_seconds_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datetime_text_to_epoch_seconds_core: "YYYY-MM-DD HH:MM:SS" to UTC seconds
// Parses a date-time text byte by byte and returns seconds since 1970.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive char_code/last_char and raise push; a transaction
//   completes on a clock edge with push high and full low. One byte per
//   cycle while full is low. last_char marks the final byte of a text.
//   Result queue: while empty is low, valid_res/epoch_seconds hold the
//   oldest result; pop with empty low takes it. One result per text.
//   Result path: after the last byte is taken, the parsed record goes
//   through the record queue, the converter sequencer steps (check, day
//   of era, day count), and the step that forms the seconds into the
//   output register; then the result shows (empty low).
//   Flow: one byte per cycle while full is low. A text needs 19 bytes to
//   be valid; the converter pops a new parsed text only when idle, after
//   its last result is loaded, so short texts back up through the record
//   queue, and full rises when it holds QUEUE_DEPTH parsed texts.
//   Stall: if the result is not popped, the converter holds its result,
//   the record queue fills and full then stops further bytes.
//   Reset (rst, synchronous): parser position and flags cleared, queues
//   emptied, converter idle; no partial text survives.
// ----------------------------------------------------------------------------
module datetime_text_to_epoch_seconds_core #(
  parameter int unsigned QUEUE_DEPTH = dte_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          char_code,
  input  logic                                last_char,
  output logic                                empty,
  input  logic                                pop,
  output logic                                valid_res,
  output logic signed [dte_pkg::SEC_W-1:0]    epoch_seconds
);
  import dte_pkg::*;

  // parsed records between the parser and the converter
  logic q_push, q_full, q_pop, q_empty;
  rec_t q_din, q_dout;
  logic out_load;

  dte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .last_char (last_char),
    .q_push    (q_push),
    .q_din     (q_din),
    .q_full    (q_full)
  );

  dte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  dte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_dout        (q_dout),
    .empty         (empty),
    .pop           (pop),
    .valid_res     (valid_res),
    .epoch_seconds (epoch_seconds),
    .out_load      (out_load)
  );

  // the parser never writes a full record queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("record pushed into full queue");

  // an invalid text always reports zero seconds
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !valid_res) |-> (epoch_seconds == '0))
    else $error("nonzero seconds on invalid result");

  // a waiting result is never overwritten before it is popped
  assert property (@(posedge clk) disable iff (rst) out_load |-> empty)
    else $error("output register overwritten");

  // a popped result with nothing new behind it leaves the result side empty
  assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !out_load) |=> empty)
    else $error("result not released after pop");

endmodule

/* hw/rtl/dte_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_front: character parser
// Checks each byte against its position, accumulates the decimal fields and
// pushes one parsed record per text on the marked last byte.
// ----------------------------------------------------------------------------
module dte_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    char_code,
  input  logic          last_char,
  output logic          q_push,
  output dte_pkg::rec_t q_din,
  input  logic          q_full
);
  import dte_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic             ferr, ferr_next;
  logic [ACC_W-1:0] yc, yl, mon, day, hr, mi, sc;
  logic [ACC_W-1:0] yc_next, yl_next, mon_next, day_next, hr_next, mi_next, sc_next;
  logic             take, is_digit, bad;
  logic [3:0]       dv;
  logic [ACC_W-1:0] acc_sel, acc_upd;

  assign full = q_full;
  assign take = push && !q_full;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dv       = is_digit ? 4'(char_code - CH_ZERO) : 4'd0;

  // pick the field this position feeds
  always_comb begin
    if (pos < 5'd2)            acc_sel = yc;
    else if (pos < POS_DASH1)  acc_sel = yl;
    else if (pos < POS_DASH2)  acc_sel = mon;
    else if (pos < POS_SPACE)  acc_sel = day;
    else if (pos < POS_COLON1) acc_sel = hr;
    else if (pos < POS_COLON2) acc_sel = mi;
    else                       acc_sel = sc;
  end

  // at most two digits per field: no overflow in 7 bits
  assign acc_upd = (acc_sel << 3) + (acc_sel << 1) + ACC_W'(dv);

  always_comb begin
    bad      = 1'b0;
    yc_next  = yc;
    yl_next  = yl;
    mon_next = mon;
    day_next = day;
    hr_next  = hr;
    mi_next  = mi;
    sc_next  = sc;
    case (pos) inside
      [POS_END:5'd31]:        bad = 1'b1;
      POS_DASH1, POS_DASH2:   bad = (char_code != CH_DASH);
      POS_SPACE:              bad = (char_code != CH_SPACE);
      POS_COLON1, POS_COLON2: bad = (char_code != CH_COLON);
      default: begin
        if (!is_digit) begin
          bad = 1'b1;
        end else if (pos < 5'd2) begin
          yc_next = acc_upd;
        end else if (pos < POS_DASH1) begin
          yl_next = acc_upd;
        end else if (pos < POS_DASH2) begin
          mon_next = acc_upd;
        end else if (pos < POS_SPACE) begin
          day_next = acc_upd;
        end else if (pos < POS_COLON1) begin
          hr_next = acc_upd;
        end else if (pos < POS_COLON2) begin
          mi_next = acc_upd;
        end else begin
          sc_next = acc_upd;
        end
      end
    endcase
    ferr_next = ferr | bad;
    pos_next  = (pos < POS_END) ? pos + 5'd1 : pos;
  end

  assign q_push       = take && last_char;
  assign q_din.fmt_ok = !ferr_next && (pos == POS_LAST);
  assign q_din.yc     = yc_next;
  assign q_din.yl     = yl_next;
  assign q_din.mon    = mon_next;
  assign q_din.day    = day_next;
  assign q_din.hr     = hr_next;
  assign q_din.mi     = mi_next;
  assign q_din.sc     = sc_next;

  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      pos  <= '0;
      ferr <= 1'b0;
      yc   <= '0;
      yl   <= '0;
      mon  <= '0;
      day  <= '0;
      hr   <= '0;
      mi   <= '0;
      sc   <= '0;
    end else if (take) begin
      pos  <= pos_next;
      ferr <= ferr_next;
      yc   <= yc_next;
      yl   <= yl_next;
      mon  <= mon_next;
      day  <= day_next;
      hr   <= hr_next;
      mi   <= mi_next;
      sc   <= sc_next;
    end
  end

endmodule

/* hw/rtl/dte_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_queue: record queue between parser and converter
// Small circular buffer; read data is registered on pop.
// ----------------------------------------------------------------------------
module dte_queue #(
  parameter int unsigned DEPTH = dte_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dte_pkg::rec_t din,
  output logic          full,
  input  logic          pop,
  output dte_pkg::rec_t dout,
  output logic          empty
);
  import dte_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rec_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
    if (do_pop) begin
      dout <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* hw/rtl/dte_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_back: range check and days-from-civil conversion
// Multi-cycle sequencer: check and split, day of era, day count, seconds.
// Holds the result in a one-entry output register until popped.
// ----------------------------------------------------------------------------
module dte_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  dte_pkg::rec_t           q_dout,
  output logic                    empty,
  input  logic                    pop,
  output logic                    valid_res,
  output logic signed [dte_pkg::SEC_W-1:0] epoch_seconds,
  output logic                    out_load
);
  import dte_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_CHK  = 5'b00010,
    B_DOE  = 5'b00100,
    B_DAYS = 5'b01000,
    B_SECS = 5'b10000
  } bstate_t;

  localparam logic signed [SEC_W-1:0] DAY_SEC  = 39'sd86400;
  localparam logic signed [23:0]      EPOCH_OF = 24'sd719468;

  bstate_t state, state_next;

  // check stage
  logic             leap, early, vld_c;
  logic [4:0]       md;
  logic [ACC_W-1:0] yc2, yl2;
  logic [8:0]       yoe_c, doy_c;
  logic [16:0]      tod_c;

  logic        vld;
  logic [4:0]  era;
  logic [8:0]  yoe;
  logic [1:0]  yoec;
  logic [8:0]  doy;
  logic [16:0] tod;
  logic [17:0] doe;
  logic [21:0] eram;
  logic signed [23:0]      days;
  logic signed [SEC_W-1:0] secs;
  logic                    out_full;

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_comb begin
    leap  = (q_dout.yl[1:0] == 2'd0) && ((q_dout.yl != '0) || (q_dout.yc[1:0] == 2'd0));
    md    = month_len(q_dout.mon, leap);
    vld_c = q_dout.fmt_ok && ((q_dout.yc != '0) || (q_dout.yl != '0)) && (md != '0) &&
            (q_dout.day != '0) && (q_dout.day <= ACC_W'(md)) &&
            (q_dout.hr <= 7'd23) && (q_dout.mi <= 7'd59) && (q_dout.sc <= 7'd59);
    // January and February count with the previous year
    early = (q_dout.mon <= 7'd2);
    yc2   = q_dout.yc;
    yl2   = q_dout.yl;
    if (early) begin
      if (q_dout.yl == '0) begin
        yc2 = q_dout.yc - 7'd1;
        yl2 = 7'd99;
      end else begin
        yl2 = q_dout.yl - 7'd1;
      end
    end
    yoe_c = 9'(yc2[1:0]) * 9'd100 + 9'(yl2);
    doy_c = doy_base(q_dout.mon) + 9'(q_dout.day) - 9'd1;
    tod_c = 17'(q_dout.hr) * 17'd3600 + 17'(q_dout.mi) * 17'd60 + 17'(q_dout.sc);
  end

  assign out_load = (state == B_SECS) && !out_full;
  assign secs     = SEC_W'(days) * DAY_SEC + $signed({22'd0, tod});

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_CHK;
      B_CHK:  state_next = B_DOE;
      B_DOE:  state_next = B_DAYS;
      B_DAYS: state_next = B_SECS;
      B_SECS: if (!out_full) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_CHK: begin
        vld  <= vld_c;
        era  <= yc2[6:2];
        yoe  <= yoe_c;
        yoec <= yc2[1:0];
        doy  <= doy_c;
        tod  <= tod_c;
      end
      B_DOE: begin
        doe  <= 18'(yoe) * 18'd365 + 18'(yoe >> 2) - 18'(yoec) + 18'(doy);
        eram <= 22'(era) * 22'd146097;
      end
      B_DAYS: begin
        days <= $signed({2'b00, eram}) + $signed({6'd0, doe}) - EPOCH_OF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      valid_res     <= vld;
      epoch_seconds <= vld ? secs : '0;
    end
  end

  assign empty = !out_full;

endmodule
